>>> src/rsa_me_pkg.sv
// Package for the modular exponentiation core: widths, defaults, codes and
// the control struct passed to the shared modular multiply unit.
// No dependencies.
package rsa_me_pkg;

   // Fixed widths of the item fields and configuration registers
   localparam int DATA_W  = 32;
   localparam int CSR_IDX_W = 2;

   // Default modulus width
   localparam int MODULUS_BITS_DEF = 32;

   // Register reset values
   localparam logic [DATA_W-1:0] MODULUS_RST  = 32'd2;
   localparam logic [DATA_W-1:0] PUB_EXP_RST  = 32'd65537;
   localparam logic [DATA_W-1:0] PRIV_EXP_RST = 32'd1;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODULUS  = 2'd0,
      CSR_PUB_EXP  = 2'd1,
      CSR_PRIV_EXP = 2'd2
   } csr_index_type;

   // Request operation codes
   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   // Shared unit operation: modular multiply or reduction of a data word
   typedef enum logic {
      MODE_MUL = 1'b0,
      MODE_RED = 1'b1
   } mmu_mode_type;

   typedef struct packed {
      logic         go;
      mmu_mode_type mode;
   } mmu_ctl_type;

endpackage

>>> src/rsa_me_if.sv
// Handshake interfaces for the request and response channels.
// Depends on rsa_me_pkg for field widths.
interface rsa_req_if import rsa_me_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [DATA_W-1:0] data_value;

   modport source (output valid, output op, output data_value, input ready);
   modport sink   (input valid, input op, input data_value, output ready);
endinterface

interface rsa_rsp_if import rsa_me_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] result_value;
   logic              range_error;

   modport source (output valid, output result_value, output range_error, input ready);
   modport sink   (input valid, input result_value, input range_error, output ready);
endinterface

>>> src/rsa_me_mmu.sv
// Shared bit-serial modular multiply / reduce unit, one operand bit a cycle.
// Depends on rsa_me_pkg.
module rsa_me_mmu import rsa_me_pkg::*; #(
   parameter int MW = MODULUS_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  mmu_ctl_type       ctl,
   input  logic [MW-1:0]     modulus,
   input  logic [MW-1:0]     opa,
   input  logic [DATA_W-1:0] opb,
   output logic              done,
   output logic [MW-1:0]     result
);

   localparam int CW = $clog2(DATA_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   mmu_mode_type      mode_ff, mode_in;
   logic [MW-1:0]     a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [MW-1:0]     acc_ff, acc_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   logic [MW:0]       r2, sum0, red0, sum1, red1;
   logic              last;

   // Two conditional-subtract reducers; the first is shared by both modes
   always_comb begin
      r2   = {acc_ff, b_ff[DATA_W-1]};
      sum0 = (mode_ff == MODE_RED) ? r2 : ({1'b0, acc_ff} + {1'b0, a_ff});
      red0 = (sum0 >= {1'b0, modulus}) ? (sum0 - {1'b0, modulus}) : sum0;
      sum1 = {1'b0, a_ff} + {1'b0, a_ff};
      red1 = (sum1 >= {1'b0, modulus}) ? (sum1 - {1'b0, modulus}) : sum1;
   end

   // Step and sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      last    = 1'b0;
      if (ctl.go) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         a_in    = opa;
         b_in    = opb;
         acc_in  = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         unique case (mode_ff)
            MODE_MUL: begin
               // acc += a when the multiplier bit is set; a doubles
               acc_in = b_ff[0] ? red0[MW-1:0] : acc_ff;
               a_in   = red1[MW-1:0];
               b_in   = b_ff >> 1;
               last   = (b_in == '0);
            end
            MODE_RED: begin
               // restoring remainder, data word MSB first
               acc_in = red0[MW-1:0];
               b_in   = b_ff << 1;
               cnt_in = cnt_ff + 1'b1;
               last   = (cnt_ff == CW'(DATA_W - 1));
            end
            default: begin
               last = 1'b1;
            end
         endcase
         busy_in = !last;
         done_in = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      cnt_ff  <= cnt_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

>>> src/rsa_modular_exponentiation_core.sv
// Top level of the RSA square-and-multiply core: configuration registers,
// exponent sequencer and response register. Depends on rsa_me_pkg,
// rsa_me_if and rsa_me_mmu.
//
//  Channel | Direction | Contents
//  --------+-----------+----------------------------------------------
//  req_ch  | in        | valid/ready, op, data_value
//  rsp_ch  | out       | valid/ready, result_value, range_error
//  csr_*   | in        | csr_we, csr_index, csr_wdata (write only)
//
// One item at a time. The base is first reduced on the shared unit, then
// each exponent bit up to the highest set one costs a decision state, a
// squaring and, for set bits, a multiply, all on the shared unit; the
// squaring after the highest set bit is skipped. Range errors, a zero
// modulus and a zero exponent skip the shared unit and go straight to the
// response. Reset is synchronous; a new item is taken while the previous
// result still waits on rsp_ch.
module rsa_modular_exponentiation_core import rsa_me_pkg::*; #(
   parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   rsa_req_if.sink              req_ch,
   rsa_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int MW = (MODULUS_BITS < DATA_W) ? MODULUS_BITS : DATA_W;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RED  = 6'b000010,
      ST_BIT  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_SQR  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] mod_ff, mod_in;
   logic [DATA_W-1:0] pub_ff, pub_in;
   logic [DATA_W-1:0] priv_ff, priv_in;
   logic [MW-1:0]     m_ff, m_in;
   logic [DATA_W-1:0] expo_ff, expo_in;
   logic [MW-1:0]     acc_ff, acc_in;
   logic [MW-1:0]     base_ff, base_in;
   logic              err_ff, err_in;
   mmu_ctl_type       ctl_ff, ctl_in;
   logic [MW-1:0]     opa_ff, opa_in;
   logic [DATA_W-1:0] opb_ff, opb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              mmu_done;
   logic [MW-1:0]     mmu_result;
   logic [MW-1:0]     m_sel;
   logic [DATA_W-1:0] expo_sel;
   logic              range_bad;

   // Configuration writes
   always_comb begin
      mod_in  = mod_ff;
      pub_in  = pub_ff;
      priv_in = priv_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODULUS:  mod_in  = csr_wdata;
            CSR_PUB_EXP:  pub_in  = csr_wdata;
            CSR_PRIV_EXP: priv_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Item decode at acceptance
   always_comb begin
      m_sel     = mod_ff[MW-1:0];
      expo_sel  = (req_ch.op == OP_DECRYPT) ? priv_ff : pub_ff;
      range_bad = (req_ch.op == OP_ENCRYPT) && (req_ch.data_value >= DATA_W'(m_sel));
   end

   // Exponent sequencer
   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      expo_in      = expo_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      err_in       = err_ff;
      ctl_in       = '{go: 1'b0, mode: MODE_MUL};
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               m_in    = m_sel;
               expo_in = expo_sel;
               err_in  = range_bad;
               opb_in  = req_ch.data_value;
               if (range_bad || m_sel == '0) begin
                  acc_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  acc_in = MW'(1);
                  if (expo_sel == '0) begin
                     state_in = ST_FIN;
                  end else begin
                     ctl_in   = '{go: 1'b1, mode: MODE_RED};
                     state_in = ST_RED;
                  end
               end
            end
         end
         ST_RED: begin
            if (mmu_done) begin
               base_in  = mmu_result;
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            ctl_in = '{go: 1'b1, mode: MODE_MUL};
            opb_in = DATA_W'(base_ff);
            if (expo_ff[0]) begin
               opa_in   = acc_ff;
               state_in = ST_MUL;
            end else begin
               opa_in   = base_ff;
               state_in = ST_SQR;
            end
         end
         ST_MUL: begin
            if (mmu_done) begin
               acc_in = mmu_result;
               // no squaring needed after the top set bit
               if (expo_ff[DATA_W-1:1] == '0) begin
                  state_in = ST_FIN;
               end else begin
                  ctl_in   = '{go: 1'b1, mode: MODE_MUL};
                  opa_in   = base_ff;
                  opb_in   = DATA_W'(base_ff);
                  state_in = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            if (mmu_done) begin
               base_in  = mmu_result;
               expo_in  = expo_ff >> 1;
               state_in = ST_BIT;
            end
         end
         ST_FIN: begin
            // wait for the response register to be free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = DATA_W'(acc_ff);
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mod_ff       <= MODULUS_RST;
         pub_ff       <= PUB_EXP_RST;
         priv_ff      <= PRIV_EXP_RST;
         ctl_ff       <= '{go: 1'b0, mode: MODE_MUL};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_ff       <= mod_in;
         pub_ff       <= pub_in;
         priv_ff      <= priv_in;
         ctl_ff       <= ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff         <= m_in;
      expo_ff      <= expo_in;
      acc_ff       <= acc_in;
      base_ff      <= base_in;
      err_ff       <= err_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   rsa_me_mmu #(
      .MW (MW)
   ) u_mmu (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl_ff),
      .modulus (m_ff),
      .opa     (opa_ff),
      .opb     (opb_ff),
      .done    (mmu_done),
      .result  (mmu_result)
   );

   // Channel outputs
   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.range_error  = rsp_err_ff;

endmodule

>>> sim/rsa_modular_exponentiation_core_tb.sv
// Self-checking bench for the RSA square-and-multiply core: directed table, then
// randomly configured phases of encrypt/decrypt items, scored against the table or a local model.
// Depends on rsa_me_pkg, rsa_me_if and the core itself.
`timescale 1ns / 1ps

module rsa_modular_exponentiation_core_tb;
   import rsa_me_pkg::*;

   localparam int RANDOM_ITEMS = 1125;
   localparam int CALM_FROM    = 1000;
   localparam int HOLD_PHASE   = 3;
   localparam int HOLD_CYCLES  = 3000;
   localparam int DRAIN_CYCLES = 40;

   // One result item as the core returns it
   typedef struct packed {
      logic [DATA_W-1:0] result_value;
      logic              range_error;
   } answer_type;

   // One row of the directed script: a register write or an item
   typedef struct {
      logic              is_write;
      csr_index_type     idx;
      op_type            op;
      logic [DATA_W-1:0] value;
      logic              known;
      answer_type        want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   rsa_req_if req_bus ();
   rsa_rsp_if rsp_bus ();

   // Register copies used by the model
   logic [DATA_W-1:0] modulus_reg;
   logic [DATA_W-1:0] pub_exp_reg;
   logic [DATA_W-1:0] priv_exp_reg;

   answer_type     answer_q [$];
   script_row_type script [$];
   int             error_count = 0;
   int             random_sent = 0;
   bit             calm = 1'b0;
   bit             hold_wanted = 1'b0;

   // Typed expectation travelling with the item on offer
   logic       offer_known;
   answer_type offer_want;
   answer_type taken_answer;

   rsa_modular_exponentiation_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Right-to-left square and multiply, products kept in 64 bits
   function automatic logic [DATA_W-1:0] power_mod(logic [DATA_W-1:0] base_in,
                                                   logic [DATA_W-1:0] expo,
                                                   logic [DATA_W-1:0] m);
      logic [63:0]       acc;
      logic [63:0]       sq;
      logic [63:0]       m64;
      logic [DATA_W-1:0] e;
      int                i;
      m64 = {32'd0, m};
      acc = 64'd1;
      sq  = {32'd0, base_in} % m64;
      e   = expo;
      for (i = 0; i < DATA_W && e != '0; i++) begin
         if (e[0])
            acc = (acc * sq) % m64;
         sq = (sq * sq) % m64;
         e  = e >> 1;
      end
      return acc[DATA_W-1:0];
   endfunction

   function automatic answer_type predict_answer(op_type op, logic [DATA_W-1:0] value);
      answer_type        a;
      logic [DATA_W-1:0] m;
      m = modulus_reg;
      a = '0;
      if (op == OP_ENCRYPT && value >= m)
         a.range_error = 1'b1;
      else if (m != '0)
         a.result_value = power_mod(value, (op == OP_DECRYPT) ? priv_exp_reg : pub_exp_reg, m);
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // Record each accepted item, score each accepted result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            taken_answer = offer_known ? offer_want
                                       : predict_answer(op_type'(req_bus.op),
                                                        req_bus.data_value);
            answer_q = {answer_q, taken_answer};
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answer_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_bus.result_value, '0);
            end else begin
               if (rsp_bus.result_value !== answer_q[0].result_value)
                  report_mismatch("result_value", rsp_bus.result_value,
                                  answer_q[0].result_value);
               if (rsp_bus.range_error !== answer_q[0].range_error)
                  report_mismatch("range_error", {31'd0, rsp_bus.range_error},
                                  {31'd0, answer_q[0].range_error});
               void'(answer_q.pop_front());
            end
         end
      end
   end

   // Result side: random stalls, one long hold-off, no stalls near the end
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
   end

   // Offer one item from a falling edge; returns on the falling edge after acceptance
   task automatic offer_item(op_type op, logic [DATA_W-1:0] value, logic known,
                             answer_type want);
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.data_value <= value;
      offer_known        <= known;
      offer_want         <= want;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
   endtask

   // Block is idle once every expected result is in
   task automatic wait_idle();
      while (answer_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [DATA_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_MODULUS:  modulus_reg  = v;
         CSR_PUB_EXP:  pub_exp_reg  = v;
         CSR_PRIV_EXP: priv_exp_reg = v;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic void add_write(csr_index_type idx, logic [DATA_W-1:0] v);
      script_row_type r;
      r = '{is_write: 1'b1, idx: idx, op: OP_ENCRYPT, value: v, known: 1'b0, want: '0};
      script = {script, r};
   endfunction

   function automatic void add_item(op_type op, logic [DATA_W-1:0] v, logic known,
                                    logic [DATA_W-1:0] res, logic err);
      script_row_type r;
      r = '{is_write: 1'b0, idx: CSR_MODULUS, op: op, value: v, known: known,
            want: '{result_value: res, range_error: err}};
      script = {script, r};
   endfunction

   function automatic logic [DATA_W-1:0] pick_modulus();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 32'd1;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'd2;
         4, 5:    return $urandom | 32'h8000_0000;
         6, 7:    return $urandom_range(2, 65535);
         default: return $urandom;
      endcase
   endfunction

   // Long exponents are slow, so most phases keep them short
   function automatic logic [DATA_W-1:0] pick_exponent(bit slow);
      if (slow)
         return ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 32'd1;
         2:       return $urandom_range(2, 15);
         5:       return 32'd65537;
         default: return $urandom_range(16, 4095);
      endcase
   endfunction

   // Mostly values below the modulus, plus the edges around it
   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] n;
      n = modulus_reg;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 32'hFFFF_FFFF;
         2:       return n - 32'd1;
         3:       return n;
         9:       return $urandom;
         default: return (n > 32'd1) ? ($urandom % n) : $urandom;
      endcase
   endfunction

   // Stimulus
   initial begin
      int     k;
      int     n_items;
      int     gap_rate;
      int     phase;
      bit     slow;
      op_type op;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_ENCRYPT;
      req_bus.data_value = '0;
      csr_we             = 1'b0;
      csr_index          = CSR_MODULUS;
      csr_wdata          = '0;
      offer_known        = 1'b0;
      offer_want         = '0;
      modulus_reg        = MODULUS_RST;
      pub_exp_reg        = PUB_EXP_RST;
      priv_exp_reg       = PRIV_EXP_RST;

      // Directed part: reset values first, then the edges of every register
      add_item(OP_ENCRYPT, 32'd0, 1'b1, 32'd0, 1'b0);
      add_item(OP_ENCRYPT, 32'd1, 1'b1, 32'd1, 1'b0);
      add_item(OP_ENCRYPT, 32'd2, 1'b1, 32'd0, 1'b1);
      add_item(OP_ENCRYPT, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1);
      add_item(OP_DECRYPT, 32'hFFFF_FFFF, 1'b1, 32'd1, 1'b0);
      add_item(OP_DECRYPT, 32'hFFFF_FFFE, 1'b1, 32'd0, 1'b0);
      add_write(CSR_MODULUS, 32'hFFFF_FFFF);
      add_write(CSR_PUB_EXP, 32'hFFFF_FFFF);
      add_write(CSR_PRIV_EXP, 32'd0);
      add_item(OP_DECRYPT, 32'd12345, 1'b1, 32'd1, 1'b0);
      add_item(OP_ENCRYPT, 32'hFFFF_FFFE, 1'b0, '0, 1'b0);
      add_item(OP_ENCRYPT, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1);
      add_item(OP_DECRYPT, 32'hFFFF_FFFF, 1'b1, 32'd1, 1'b0);
      // modulus of one
      add_write(CSR_MODULUS, 32'd1);
      add_write(CSR_PRIV_EXP, 32'd5);
      add_item(OP_DECRYPT, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0);
      add_item(OP_ENCRYPT, 32'd0, 1'b1, 32'd0, 1'b0);
      add_item(OP_ENCRYPT, 32'd1, 1'b1, 32'd0, 1'b1);
      add_write(CSR_PUB_EXP, 32'd0);
      add_item(OP_ENCRYPT, 32'd0, 1'b1, 32'd1, 1'b0);
      // modulus of zero: encrypt always flags, decrypt yields zero
      add_write(CSR_MODULUS, 32'd0);
      add_item(OP_ENCRYPT, 32'd0, 1'b1, 32'd0, 1'b1);
      add_item(OP_ENCRYPT, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1);
      add_item(OP_DECRYPT, 32'hABCD_EF01, 1'b1, 32'd0, 1'b0);
      // textbook key pair
      add_write(CSR_MODULUS, 32'd3233);
      add_write(CSR_PUB_EXP, 32'd17);
      add_write(CSR_PRIV_EXP, 32'd2753);
      add_item(OP_ENCRYPT, 32'd65, 1'b0, '0, 1'b0);
      add_item(OP_DECRYPT, 32'd2790, 1'b0, '0, 1'b0);
      add_item(OP_ENCRYPT, 32'd3232, 1'b0, '0, 1'b0);
      add_item(OP_ENCRYPT, 32'd3233, 1'b1, 32'd0, 1'b1);
      add_item(OP_DECRYPT, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
      // large prime modulus
      add_write(CSR_MODULUS, 32'hFFFF_FFFB);
      add_write(CSR_PUB_EXP, PUB_EXP_RST);
      add_write(CSR_PRIV_EXP, 32'h8000_0001);
      add_item(OP_ENCRYPT, 32'hFFFF_FFFA, 1'b0, '0, 1'b0);
      add_item(OP_DECRYPT, 32'h8000_0000, 1'b0, '0, 1'b0);

      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (script[i]) begin
         if (script[i].is_write) begin
            req_bus.valid <= 1'b0;
            wait_idle();
            write_csr(script[i].idx, script[i].value);
         end else begin
            offer_item(script[i].op, script[i].value, script[i].known, script[i].want);
         end
      end
      req_bus.valid <= 1'b0;

      // Random phases, each under a fresh register setting
      phase = 0;
      while (random_sent < RANDOM_ITEMS) begin
         slow = (phase != HOLD_PHASE) && ($urandom_range(0, 5) == 0);
         wait_idle();
         write_csr(CSR_MODULUS, pick_modulus());
         write_csr(CSR_PUB_EXP, pick_exponent(slow));
         write_csr(CSR_PRIV_EXP, pick_exponent(slow && $urandom_range(0, 1) == 1));
         gap_rate = $urandom_range(0, 3);
         n_items  = slow ? 8 : $urandom_range(20, 60);
         if (phase == HOLD_PHASE) begin
            n_items     = 60;
            hold_wanted = 1'b1;
         end
         for (k = 0; k < n_items && random_sent < RANDOM_ITEMS; k++) begin
            if (!calm && gap_rate != 0 && $urandom_range(0, 3) < gap_rate) begin
               req_bus.valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(negedge clock);
            end
            op = op_type'($urandom_range(0, 1));
            offer_item(op, pick_value(), 1'b0, '0);
            random_sent++;
            if (random_sent >= CALM_FROM)
               calm = 1'b1;
         end
         req_bus.valid <= 1'b0;
         phase++;
      end

      // Drain, then a short quiet tail
      while (answer_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("[rsa_modular_exponentiation_core] OK");
      else
         $display("[rsa_modular_exponentiation_core] ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #100_000_000;
      $display("[rsa_modular_exponentiation_core] ERROR");
      $finish;
   end

endmodule
